>>> src/mf3_pkg.sv
// shared constants, types and compare helpers of the 3x3 rgb median filter
package mf3_pkg;

	localparam int MAX_WIDTH    = 1024;
	localparam int MAX_HEIGHT   = 4096;
	localparam int COL_W        = $clog2(MAX_WIDTH);
	localparam int ROW_W        = $clog2(MAX_HEIGHT);
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;
	localparam int CFG_DATA_W   = 13;
	localparam int CH_W         = 8;
	localparam int NUM_CH       = 3;
	localparam int PIX_W        = CH_W * NUM_CH;
	localparam int WIN_DIM      = 3;
	localparam int WIN_TAPS     = WIN_DIM * WIN_DIM;
	localparam int MIN_SIZE     = 3;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(640);
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(480);

	typedef enum logic [0:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef logic [CH_W-1:0]  chan_t;
	typedef logic [PIX_W-1:0] pix_t;

	// which results a word still owes
	typedef struct packed {
		logic current;
		logic above;
		logic center;
	} pend_t;

	typedef struct packed {
		pix_t             center;
		pix_t             above_new;
		pix_t             current;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             interior;
		pend_t            rel;
	} side_t;

	typedef struct packed {
		side_t                   side;
		pix_t [WIN_TAPS-1:0]     win;
	} job_t;

	typedef struct packed {
		chan_t hi;
		chan_t mid;
		chan_t lo;
	} trio_t;

	function automatic trio_t sort3(chan_t a, chan_t b, chan_t c);
		chan_t x;
		chan_t y;
		chan_t z;
		chan_t t;
		trio_t res;
		x = a;
		y = b;
		z = c;
		if (x > y) begin
			t = x; x = y; y = t;
		end
		if (y > z) begin
			t = y; y = z; z = t;
		end
		if (x > y) begin
			t = x; x = y; y = t;
		end
		res.lo  = x;
		res.mid = y;
		res.hi  = z;
		return res;
	endfunction

	function automatic chan_t max3(chan_t a, chan_t b, chan_t c);
		chan_t m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	function automatic chan_t min3(chan_t a, chan_t b, chan_t c);
		chan_t m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

	function automatic chan_t med3(chan_t a, chan_t b, chan_t c);
		trio_t s;
		s = sort3(a, b, c);
		return s.mid;
	endfunction

endpackage

>>> src/mf3_pix_if.sv
// pixel channel: one raster-order rgb pixel per word
interface mf3_pix_if
	import mf3_pkg::*;
();
	logic  valid;
	logic  ready;
	chan_t in_blue;
	chan_t in_green;
	chan_t in_red;

	modport source (output valid, output in_blue, output in_green, output in_red, input ready);
	modport sink (input valid, input in_blue, input in_green, input in_red, output ready);
endinterface

>>> src/mf3_res_if.sv
// result channel: one filtered or passed-through pixel with its position per word
interface mf3_res_if
	import mf3_pkg::*;
();
	logic             valid;
	logic             ready;
	chan_t            out_blue;
	chan_t            out_green;
	chan_t            out_red;
	logic [ROW_W-1:0] out_row;
	logic [COL_W-1:0] out_col;
	logic             is_filtered;
	logic             last_of_run;

	modport source (output valid, output out_blue, output out_green, output out_red,
		output out_row, output out_col, output is_filtered, output last_of_run, input ready);
	modport sink (input valid, input out_blue, input out_green, input out_red,
		input out_row, input out_col, input is_filtered, input last_of_run, output ready);
endinterface

>>> src/mf3_cfg_if.sv
// configuration write channel: register index and write data
interface mf3_cfg_if
	import mf3_pkg::*;
();
	logic                  valid;
	logic                  ready;
	cfg_reg_t              index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/median_filter_3x3_rgb.sv
// a releasing pixel's results pass stage 1, the job queue, stage 2, stage 3 and the output register
// throughput: one pixel word per cycle while each pixel releases at most one result and the result side is ready
// the result port sends at most one word per cycle, so row ends and the last row slow the input
// a 2-entry job queue and the two back stages absorb short result-side stalls
// reset: counters cleared, frame size 640 x 480, line stores and window keep old contents
// no clearing pass after reset, pixels are accepted from the first cycle
module median_filter_3x3_rgb
	import mf3_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	mf3_pix_if.sink   pixel,
	mf3_res_if.source result,
	mf3_cfg_if.sink   cfg
);

	// front to queue
	job_t push_job;
	logic push;
	logic q_full;

	// queue to back
	job_t head_job;
	logic head_valid;
	logic pop;

	// counters, size registers, line stores and window; one pixel word per cycle while the job queue has room
	mf3_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pixel    (pixel),
		.cfg      (cfg),
		.job      (push_job),
		.job_push (push),
		.q_full   (q_full)
	);

	// decouples the front end from result-side stalls
	mf3_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_job   (push_job),
		.push     (push),
		.full     (q_full),
		.rd_job   (head_job),
		.rd_valid (head_valid),
		.pop      (pop)
	);

	// column sort, reduction, final median and one result word per cycle while the result side is ready
	mf3_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (head_job),
		.job_valid (head_valid),
		.job_pop   (pop),
		.result    (result)
	);

endmodule

>>> src/mf3_front.sv
// front end: frame counters, line stores, 3x3 window and release classification
module mf3_front
	import mf3_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	mf3_pix_if.sink pixel,
	mf3_cfg_if.sink cfg,
	output job_t    job,
	output logic    job_push,
	input  logic    q_full
);

	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;
	logic [WIDTH_REG_W-1:0]  w_eff;
	logic [HEIGHT_REG_W-1:0] h_eff;

	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;

	logic             valid_s1;
	pix_t             pix_s1;
	logic [ROW_W-1:0] row_s1;
	logic [COL_W-1:0] col_s1;
	logic             interior_s1;
	pend_t            rel_s1;

	pix_t above_mem [MAX_WIDTH];
	pix_t two_mem [MAX_WIDTH];
	pix_t above_rd_q;
	pix_t two_rd_q;

	pix_t [WIN_TAPS-1:0] win_q;
	pix_t [WIN_TAPS-1:0] win_next;

	logic                   pix_fire;
	logic                   s1_fire;
	logic                   has_res_s1;
	logic [WIDTH_REG_W-1:0] col_ext;
	logic [HEIGHT_REG_W-1:0] row_ext;
	logic                   row_end;
	logic                   last_row;
	logic                   interior;
	pend_t                  rel;

	// size registers, saturated to the legal range
	always_comb begin
		if (width_q < WIDTH_REG_W'(MIN_SIZE)) begin
			w_eff = WIDTH_REG_W'(MIN_SIZE);
		end else if (width_q > WIDTH_REG_W'(MAX_WIDTH)) begin
			w_eff = WIDTH_REG_W'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		if (height_q < HEIGHT_REG_W'(MIN_SIZE)) begin
			h_eff = HEIGHT_REG_W'(MIN_SIZE);
		end else if (height_q > HEIGHT_REG_W'(MAX_HEIGHT)) begin
			h_eff = HEIGHT_REG_W'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
	end

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_FRAME_WIDTH:  width_q  <= cfg.data[WIDTH_REG_W-1:0];
				REG_FRAME_HEIGHT: height_q <= cfg.data[HEIGHT_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// classification of the incoming pixel against the frame size
	always_comb begin
		col_ext      = {1'b0, col_q};
		row_ext      = {1'b0, row_q};
		row_end      = col_ext >= (w_eff - WIDTH_REG_W'(1));
		last_row     = row_ext >= (h_eff - HEIGHT_REG_W'(1));
		interior     = (row_q >= ROW_W'(2)) && (row_ext < h_eff)
			&& (col_q >= COL_W'(2)) && (col_ext < w_eff);
		rel.center   = (row_q != '0) && (col_q != '0);
		rel.above    = (row_q != '0) && row_end;
		rel.current  = last_row;
	end

	assign has_res_s1  = rel_s1.center | rel_s1.above | rel_s1.current;
	assign s1_fire     = valid_s1 & (~has_res_s1 | ~q_full);
	assign pixel.ready = ~valid_s1 | s1_fire;
	assign pix_fire    = pixel.valid & pixel.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			col_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (pix_fire) begin
				valid_s1 <= 1'b1;
				if (row_end) begin
					col_q <= '0;
					row_q <= last_row ? '0 : ROW_W'(row_q + 1'b1);
				end else begin
					col_q <= COL_W'(col_q + 1'b1);
				end
			end else if (s1_fire) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix_fire) begin
			pix_s1      <= {pixel.in_red, pixel.in_green, pixel.in_blue};
			row_s1      <= row_q;
			col_s1      <= col_q;
			interior_s1 <= interior;
			rel_s1      <= rel;
		end
	end

	// line stores: read when the pixel comes in, rotate when it leaves stage 1
	always_ff @(posedge clk) begin
		if (pix_fire) begin
			above_rd_q <= above_mem[col_q];
			two_rd_q   <= two_mem[col_q];
		end
		if (s1_fire) begin
			two_mem[col_s1]   <= above_rd_q;
			above_mem[col_s1] <= pix_s1;
		end
	end

	always_comb begin
		for (int i = 0; i < WIN_DIM; i++) begin
			win_next[i*WIN_DIM]     = win_q[i*WIN_DIM + 1];
			win_next[i*WIN_DIM + 1] = win_q[i*WIN_DIM + 2];
		end
		win_next[WIN_DIM - 1]       = two_rd_q;
		win_next[2*WIN_DIM - 1]     = above_rd_q;
		win_next[WIN_TAPS - 1]      = pix_s1;
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			win_q <= win_next;
		end
	end

	always_comb begin
		job.win             = win_next;
		job.side.center     = win_next[WIN_DIM + 1];
		job.side.above_new  = above_rd_q;
		job.side.current    = pix_s1;
		job.side.row        = row_s1;
		job.side.col        = col_s1;
		job.side.interior   = interior_s1;
		job.side.rel        = rel_s1;
	end

	assign job_push = s1_fire & has_res_s1;

`ifndef SYNTH
	a_no_addr_clash: assert property (@(posedge clk) disable iff (!arst_n)
		pix_fire && s1_fire |-> col_q != col_s1)
		else $error("line store read and write hit the same column");
`endif

endmodule

>>> src/mf3_queue.sv
// short job queue between front end and median back end
module mf3_queue
	import mf3_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  job_t wr_job,
	input  logic push,
	output logic full,
	output job_t rd_job,
	output logic rd_valid,
	input  logic pop
);

	job_t              slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full     = count_q == (QPTR_W + 1)'(QUEUE_DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_job   = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= QPTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= QPTR_W'(rd_ptr_q + 1'b1);
			end
			case ({push, pop})
				2'b10:   count_q <= (QPTR_W + 1)'(count_q + 1'b1);
				2'b01:   count_q <= (QPTR_W + 1)'(count_q - 1'b1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wr_job;
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && full |-> pop)
		else $error("job pushed into a full queue");
`endif
`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_W + 1)'(QUEUE_DEPTH))
		else $error("queue count beyond depth");
`endif

endmodule

>>> src/mf3_back.sv
// back end: pipelined median network per channel and serial result emission
module mf3_back
	import mf3_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  job_t        job,
	input  logic        job_valid,
	output logic        job_pop,
	mf3_res_if.source   result
);

	// stage 2: each window column sorted, per channel
	logic                             valid_s2;
	trio_t [NUM_CH-1:0][WIN_DIM-1:0]  cols_s2;
	side_t                            side_s2;
	trio_t [NUM_CH-1:0][WIN_DIM-1:0]  cols_d;

	// stage 3: max of lows, median of mids, min of highs
	logic                 valid_s3;
	trio_t [NUM_CH-1:0]   red_s3;
	side_t                side_s3;
	pend_t                pend_s3;
	trio_t [NUM_CH-1:0]   red_d;

	logic             out_valid_q;
	chan_t            blue_q;
	chan_t            green_q;
	chan_t            red_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic             filt_q;
	logic             last_q;

	logic             s2_ready;
	logic             s3_ready;
	logic             adv_s2;
	logic             out_load;
	logic             s3_done;
	pend_t            sel;
	pend_t            pend_left;
	pix_t             median;
	pix_t             res_pix;
	logic [ROW_W-1:0] res_row;
	logic [COL_W-1:0] res_col;
	logic             res_filt;

	assign out_load = valid_s3 & (~out_valid_q | result.ready);
	assign s3_done  = out_load & (pend_left == '0);
	assign s3_ready = ~valid_s3 | s3_done;
	assign adv_s2   = valid_s2 & s3_ready;
	assign s2_ready = ~valid_s2 | adv_s2;
	assign job_pop  = job_valid & s2_ready;

	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			for (int j = 0; j < WIN_DIM; j++) begin
				cols_d[ch][j] = sort3(job.win[j][ch*CH_W +: CH_W],
					job.win[WIN_DIM + j][ch*CH_W +: CH_W],
					job.win[2*WIN_DIM + j][ch*CH_W +: CH_W]);
			end
		end
	end

	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			red_d[ch].lo  = max3(cols_s2[ch][0].lo, cols_s2[ch][1].lo, cols_s2[ch][2].lo);
			red_d[ch].mid = med3(cols_s2[ch][0].mid, cols_s2[ch][1].mid, cols_s2[ch][2].mid);
			red_d[ch].hi  = min3(cols_s2[ch][0].hi, cols_s2[ch][1].hi, cols_s2[ch][2].hi);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (job_pop) begin
				valid_s2 <= 1'b1;
			end else if (adv_s2) begin
				valid_s2 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s3 <= 1'b1;
			end else if (s3_done) begin
				valid_s3 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			cols_s2 <= cols_d;
			side_s2 <= job.side;
		end
		if (adv_s2) begin
			red_s3  <= red_d;
			side_s3 <= side_s2;
			pend_s3 <= side_s2.rel;
		end else if (out_load) begin
			pend_s3 <= pend_left;
		end
	end

	// results leave in order: window centre, row-end pixel above, last-row pixel
	always_comb begin
		sel = '0;
		if (pend_s3.center) begin
			sel.center = 1'b1;
		end else if (pend_s3.above) begin
			sel.above = 1'b1;
		end else begin
			sel.current = pend_s3.current;
		end
		pend_left.center  = pend_s3.center & ~sel.center;
		pend_left.above   = pend_s3.above & ~sel.above;
		pend_left.current = pend_s3.current & ~sel.current;

		for (int ch = 0; ch < NUM_CH; ch++) begin
			median[ch*CH_W +: CH_W] = med3(red_s3[ch].lo, red_s3[ch].mid, red_s3[ch].hi);
		end

		if (sel.center) begin
			res_pix  = side_s3.interior ? median : side_s3.center;
			res_row  = ROW_W'(side_s3.row - 1'b1);
			res_col  = COL_W'(side_s3.col - 1'b1);
			res_filt = side_s3.interior;
		end else if (sel.above) begin
			res_pix  = side_s3.above_new;
			res_row  = ROW_W'(side_s3.row - 1'b1);
			res_col  = side_s3.col;
			res_filt = 1'b0;
		end else begin
			res_pix  = side_s3.current;
			res_row  = side_s3.row;
			res_col  = side_s3.col;
			res_filt = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			blue_q  <= res_pix[0 +: CH_W];
			green_q <= res_pix[CH_W +: CH_W];
			red_q   <= res_pix[2*CH_W +: CH_W];
			row_q   <= res_row;
			col_q   <= res_col;
			filt_q  <= res_filt;
			last_q  <= pend_left == '0;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.out_blue    = blue_q;
	assign result.out_green   = green_q;
	assign result.out_red     = red_q;
	assign result.out_row     = row_q;
	assign result.out_col     = col_q;
	assign result.is_filtered = filt_q;
	assign result.last_of_run = last_q;

`ifndef SYNTH
	a_s3_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> pend_s3 != '0)
		else $error("emission stage holds a word with nothing to release");
`endif
`ifndef SYNTH
	a_one_sel: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> $onehot(sel))
		else $error("emission picked no result or several at once");
`endif

endmodule

>>> bench/median_filter_3x3_rgb_tb.sv
`timescale 1ns / 100ps
// self-checking bench for the 3x3 rgb median filter: raster frames in, released pixels checked in order
module median_filter_3x3_rgb_tb;
	import mf3_pkg::*;

	// assumed pipeline depth, and the settle time used after a drain
	localparam int LATENCY      = 4;
	localparam int SETTLE       = 3 * LATENCY;
	localparam int RANDOM_ITEMS = 250;
	localparam int PRINT_CAP    = 100;

	// content styles for generated pixels
	typedef enum int {
		PX_ANY,
		PX_TIES,
		PX_EXTREME
	} pix_style_t;

	// receiver behavior, switched phase by phase
	typedef enum int {
		SINK_OPEN,
		SINK_RANDOM,
		SINK_TOGGLE,
		SINK_RUNS
	} sink_style_t;

	// one expected word on the result side
	typedef struct {
		chan_t            red;
		chan_t            green;
		chan_t            blue;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             filtered;
		logic             last;
	} res_word_t;

	logic clk;
	logic arst_n;

	mf3_pix_if pix_bus ();
	mf3_res_if res_bus ();
	mf3_cfg_if cfg_bus ();

	median_filter_3x3_rgb uut (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pix_bus),
		.result (res_bus),
		.cfg    (cfg_bus)
	);

	// predictor state: two line buffers, the 3x3 neighborhood and the raster position
	pix_t                    prev_row [MAX_WIDTH] = '{default: '0};
	pix_t                    prev_prev_row [MAX_WIDTH] = '{default: '0};
	pix_t                    nbhd [3][3] = '{default: '0};
	int unsigned             pos_row = 0;
	int unsigned             pos_col = 0;
	logic [WIDTH_REG_W-1:0]  width_setting = WIDTH_RESET;
	logic [HEIGHT_REG_W-1:0] height_setting = HEIGHT_RESET;

	// released pixels still owed by the block, oldest first
	res_word_t expected_pixels [$];

	int unsigned mismatch_count = 0;
	int unsigned pixels_sent = 0;
	int unsigned burst_left = 0;
	int unsigned tie_base = 100;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop well past the slowest legal run
	initial begin
		#40_000_000;
		$display("tb: failure");
		$finish;
	end

	// out-of-range sizes saturate into the legal range
	function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
		if (v < MIN_SIZE)
			return MIN_SIZE;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// median of nine by rank: the value with at most four below it and at least five at or below
	function automatic chan_t median_nine(input pix_t taps [9], input int ch);
		chan_t v [9];
		int    lt;
		int    le;
		for (int i = 0; i < 9; i++)
			v[i] = taps[i][ch*CH_W +: CH_W];
		for (int i = 0; i < 9; i++) begin
			lt = 0;
			le = 0;
			for (int j = 0; j < 9; j++) begin
				if (v[j] < v[i])
					lt++;
				if (v[j] <= v[i])
					le++;
			end
			if (lt <= 4 && le >= 5)
				return v[i];
		end
		return '0;
	endfunction

	function automatic res_word_t make_word(input pix_t p, input int unsigned row,
			input int unsigned col, input logic filtered);
		res_word_t w;
		w.blue     = p[7:0];
		w.green    = p[15:8];
		w.red      = p[23:16];
		w.row      = row[ROW_W-1:0];
		w.col      = col[COL_W-1:0];
		w.filtered = filtered;
		w.last     = 1'b0;
		return w;
	endfunction

	// advance the predictor by one accepted pixel and queue what it releases
	function automatic void compute_released_pixels(input pix_t p);
		int unsigned w;
		int unsigned h;
		int unsigned r;
		int unsigned c;
		int unsigned idx;
		bit          row_end;
		bit          last_row;
		pix_t        taps [9];
		pix_t        med;
		res_word_t   outs [$];
		w        = clamp_size(width_setting, MAX_WIDTH);
		h        = clamp_size(height_setting, MAX_HEIGHT);
		r        = pos_row;
		c        = pos_col;
		idx      = c % MAX_WIDTH;
		row_end  = (c + 1 >= w);
		last_row = (r + 1 >= h);

		// shift the neighborhood left, new column from the line buffers and the input
		for (int k = 0; k < 3; k++) begin
			nbhd[k][0] = nbhd[k][1];
			nbhd[k][1] = nbhd[k][2];
		end
		nbhd[0][2] = prev_prev_row[idx];
		nbhd[1][2] = prev_row[idx];
		nbhd[2][2] = p;
		prev_prev_row[idx] = prev_row[idx];
		prev_row[idx]      = p;

		// pixel up and to the left: median only if it sits strictly inside the frame
		if (r >= 1 && c >= 1) begin
			if (r >= 2 && r < h && c >= 2 && c < w) begin
				for (int i = 0; i < 3; i++)
					for (int j = 0; j < 3; j++)
						taps[i*3+j] = nbhd[i][j];
				for (int ch = 0; ch < NUM_CH; ch++)
					med[ch*CH_W +: CH_W] = median_nine(taps, ch);
				outs.push_back(make_word(med, r - 1, c - 1, 1'b1));
			end else begin
				outs.push_back(make_word(nbhd[1][1], r - 1, c - 1, 1'b0));
			end
		end
		// right edge of the row above
		if (r >= 1 && row_end)
			outs.push_back(make_word(nbhd[1][2], r - 1, c, 1'b0));
		// bottom row goes straight through
		if (last_row)
			outs.push_back(make_word(p, r, c, 1'b0));
		if (outs.size() > 0)
			outs[outs.size()-1].last = 1'b1;
		foreach (outs[i])
			expected_pixels.push_back(outs[i]);

		if (row_end) begin
			pos_col = 0;
			pos_row = last_row ? 0 : r + 1;
		end else begin
			pos_col = c + 1;
		end
	endfunction

	function automatic pix_t random_pixel(input pix_style_t style);
		pix_t p;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			case (style)
			PX_TIES: begin
				p[ch*CH_W +: CH_W] = CH_W'(tie_base + $urandom_range(0, 2));
			end
			PX_EXTREME: begin
				p[ch*CH_W +: CH_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			end
			default: begin
				p[ch*CH_W +: CH_W] = CH_W'($urandom_range(0, 255));
			end
			endcase
		end
		return p;
	endfunction

	task automatic report_mismatch(input string what, input res_word_t want,
			input logic [31:0] exp_val, input logic [31:0] got_val);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("mismatch %s at row %0d col %0d: expected %0h got %0h (t=%0t)",
				what, want.row, want.col, exp_val, got_val, $realtime);
	endtask

	// compare one accepted result word against the oldest owed pixel
	task automatic check_result_word();
		res_word_t want;
		if (expected_pixels.size() == 0) begin
			want = make_word('0, res_bus.out_row, res_bus.out_col, 1'b0);
			report_mismatch("word with nothing owed", want, 0, 1);
			return;
		end
		want = expected_pixels.pop_front();
		if (res_bus.out_red !== want.red)
			report_mismatch("red", want, want.red, res_bus.out_red);
		if (res_bus.out_green !== want.green)
			report_mismatch("green", want, want.green, res_bus.out_green);
		if (res_bus.out_blue !== want.blue)
			report_mismatch("blue", want, want.blue, res_bus.out_blue);
		if (res_bus.out_row !== want.row)
			report_mismatch("row", want, want.row, res_bus.out_row);
		if (res_bus.out_col !== want.col)
			report_mismatch("col", want, want.col, res_bus.out_col);
		if (res_bus.is_filtered !== want.filtered)
			report_mismatch("is_filtered", want, want.filtered, res_bus.is_filtered);
		if (res_bus.last_of_run !== want.last)
			report_mismatch("last_of_run", want, want.last, res_bus.last_of_run);
	endtask

	// sampled at the edge, before any of this step's updates land
	always @(posedge clk) begin
		if (arst_n === 1'b1 && res_bus.valid === 1'b1 && res_bus.ready === 1'b1)
			check_result_word();
	end

	// result side back-pressure: phases of open flow, coin flips, toggling and stall runs
	initial begin : result_sink
		int unsigned phase_left;
		int unsigned run_left;
		sink_style_t style;
		bit          level;
		phase_left = 0;
		run_left   = 0;
		style      = SINK_OPEN;
		level      = 1'b0;
		res_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (phase_left == 0) begin
				phase_left = $urandom_range(20, 200);
				style      = sink_style_t'($urandom_range(0, 3));
			end
			phase_left--;
			case (style)
			SINK_OPEN: begin
				level = 1'b1;
			end
			SINK_RANDOM: begin
				level = ($urandom_range(0, 9) < 7);
			end
			SINK_TOGGLE: begin
				level = !level;
			end
			default: begin
				if (run_left == 0) begin
					level    = !level;
					run_left = level ? $urandom_range(1, 8) : $urandom_range(1, 6);
				end
				run_left--;
			end
			endcase
			res_bus.ready <= level;
		end
	end

	// present one pixel word, wait for it to be taken, then maybe open a gap
	task automatic send_pixel(input pix_t p);
		int unsigned gap;
		pix_bus.valid    <= 1'b1;
		pix_bus.in_blue  <= p[7:0];
		pix_bus.in_green <= p[15:8];
		pix_bus.in_red   <= p[23:16];
		do
			@(posedge clk);
		while (pix_bus.ready !== 1'b1);
		compute_released_pixels(p);
		pixels_sent++;
		if (burst_left != 0)
			burst_left--;
		if (burst_left == 0) begin
			// mostly short bursts, now and then a long unbroken stretch
			burst_left = ($urandom_range(0, 9) < 3) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
			gap = $urandom_range(1, 4);
			pix_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold the input off until every owed pixel is out, then let the pipe settle
	task automatic quiesce();
		pix_bus.valid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// only called while the block is idle
	task automatic write_reg(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] value);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= which;
		cfg_bus.data  <= value;
		do
			@(posedge clk);
		while (cfg_bus.ready !== 1'b1);
		cfg_bus.valid <= 1'b0;
		if (which == REG_FRAME_WIDTH)
			width_setting = value[WIDTH_REG_W-1:0];
		else
			height_setting = value[HEIGHT_REG_W-1:0];
		@(posedge clk);
	endtask

	task automatic set_frame_size(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
		quiesce();
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
	endtask

	// at least one pixel, then on until the raster position wraps to the frame origin
	task automatic run_to_frame_end(input pix_style_t style);
		do
			send_pixel(random_pixel(style));
		while (pos_row != 0 || pos_col != 0);
	endtask

	// sizes out of reset: a stretch of row 0 releases nothing, then shrink to 3x3 mid-row
	task automatic test_reset_defaults();
		repeat (20) send_pixel(random_pixel(PX_ANY));
		quiesce();
		write_reg(REG_FRAME_WIDTH, 3);
		write_reg(REG_FRAME_HEIGHT, 3);
		run_to_frame_end(PX_ANY);
	endtask

	// smallest frame, once through saturation from below and once at exactly 3x3
	task automatic test_smallest_frames();
		pix_t corner_values [9];
		corner_values = '{24'hFFFFFF, 24'h000000, 24'hFF00FF, 24'h00FF00, 24'h808080,
			24'h7F7F7F, 24'h010203, 24'hFEFDFC, 24'hFFFFFF};
		set_frame_size(0, 2);
		foreach (corner_values[i])
			send_pixel(corner_values[i]);
		set_frame_size(3, 3);
		run_to_frame_end(PX_EXTREME);
	endtask

	// 5x4 frame with a ramp on red and on green and blue alternating between 00 and FF
	task automatic test_channel_medians();
		set_frame_size(5, 4);
		for (int i = 0; i < 20; i++)
			send_pixel({8'(i * 37), 8'(255 - i * 11), (i % 2) ? 8'hFF : 8'h00});
	endtask

	// shrink height below the current row, then width below the current column
	task automatic test_mid_frame_shrink();
		set_frame_size(6, 8);
		repeat (26) send_pixel(random_pixel(PX_ANY));
		quiesce();
		write_reg(REG_FRAME_HEIGHT, 3);
		send_pixel(random_pixel(PX_ANY));
		quiesce();
		write_reg(REG_FRAME_WIDTH, 3);
		run_to_frame_end(PX_ANY);
	endtask

	// small random frames with random content, occasional pauses and mid-frame shrinks
	task automatic test_random_frames();
		int unsigned start_count;
		int unsigned w;
		int unsigned h;
		int unsigned eff_w;
		int unsigned eff_h;
		int unsigned cut;
		int unsigned pick;
		pix_style_t  style;
		bit          first;
		start_count = pixels_sent;
		first       = 1'b1;
		while (pixels_sent - start_count < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
			0: w = $urandom_range(0, 2);
			1: w = $urandom_range(11, 40);
			default: w = $urandom_range(3, 10);
			endcase
			h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
			quiesce();
			// width carries junk in the bits above its register
			pick = first ? 2 : $urandom_range(0, 5);
			if (pick != 1)
				write_reg(REG_FRAME_WIDTH, {2'($urandom_range(0, 3)), 11'(w)});
			if (pick != 0)
				write_reg(REG_FRAME_HEIGHT, 13'(h));
			first    = 1'b0;
			style    = pix_style_t'($urandom_range(0, 2));
			tie_base = $urandom_range(0, 253);
			eff_w    = clamp_size(width_setting, MAX_WIDTH);
			eff_h    = clamp_size(height_setting, MAX_HEIGHT);
			cut      = $urandom_range(1, eff_w * eff_h - 1);
			case ($urandom_range(0, 9))
			0, 1: begin
				// shrink one dimension partway through the frame
				repeat (cut) send_pixel(random_pixel(style));
				quiesce();
				if ($urandom_range(0, 1))
					write_reg(REG_FRAME_WIDTH, 13'($urandom_range(MIN_SIZE, eff_w)));
				else
					write_reg(REG_FRAME_HEIGHT, 13'($urandom_range(MIN_SIZE, eff_h)));
				run_to_frame_end(style);
			end
			2: begin
				// let the block run dry partway through the frame
				repeat (cut) send_pixel(random_pixel(style));
				quiesce();
				run_to_frame_end(style);
			end
			default: begin
				run_to_frame_end(style);
			end
			endcase
		end
	endtask

	// widest rows (saturated and exact with masked upper bits) and the tallest frame,
	// each run partway and then cut short by a shrink
	task automatic test_largest_frames();
		set_frame_size(2047, 3);
		repeat (40) send_pixel(random_pixel(PX_ANY));
		quiesce();
		write_reg(REG_FRAME_WIDTH, 3);
		run_to_frame_end(PX_ANY);
		quiesce();
		write_reg(REG_FRAME_WIDTH, 13'h1400);
		repeat (40) send_pixel(random_pixel(PX_ANY));
		quiesce();
		write_reg(REG_FRAME_WIDTH, 3);
		run_to_frame_end(PX_ANY);
		set_frame_size(3, 8191);
		repeat (24) send_pixel(random_pixel(PX_ANY));
		quiesce();
		write_reg(REG_FRAME_HEIGHT, 3);
		run_to_frame_end(PX_ANY);
	endtask

	initial begin
		arst_n           <= 1'b0;
		pix_bus.valid    <= 1'b0;
		pix_bus.in_blue  <= '0;
		pix_bus.in_green <= '0;
		pix_bus.in_red   <= '0;
		cfg_bus.valid    <= 1'b0;
		cfg_bus.index    <= REG_FRAME_WIDTH;
		cfg_bus.data     <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_smallest_frames();
		test_channel_medians();
		test_mid_frame_shrink();
		test_random_frames();
		test_largest_frames();

		// drain everything still owed before the verdict
		quiesce();
		if (mismatch_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
